// ===== design/sspq_pkg.sv =====
// shared types and constants for the stable sorted priority queue
package sspq_pkg;

  // queue geometry
  localparam int DEPTH        = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_W        = $clog2(DEPTH + 1);

  // port field widths
  localparam int OP_W   = 1;
  localparam int PRIO_W = 8;
  localparam int TAG_W  = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } sspq_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } sspq_status_e;

  // one stored entry
  typedef struct packed {
    logic [PRIO_W-1:0]       key;
    logic [PAYLOAD_BITS-1:0] tag;
  } sspq_entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } sspq_ctrl_t;

endpackage

// ===== design/sspq_if.sv =====
// request and response channel interfaces
interface sspq_req_if;
  import sspq_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [PRIO_W-1:0] priority_req;
  logic [TAG_W-1:0]  payload;

  modport source (output valid, op, priority_req, payload, input ready);
  modport sink   (input valid, op, priority_req, payload, output ready);
endinterface

interface sspq_rsp_if;
  import sspq_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PRIO_W-1:0] out_priority;
  logic [TAG_W-1:0]  out_payload;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, status, out_priority, out_payload, occupancy, input ready);
  modport sink   (input valid, status, out_priority, out_payload, occupancy, output ready);
endinterface

// ===== design/stable_sorted_priority_queue.sv =====
// top level: sorted row of cells with count and response register
//
// Bounded priority queue of DEPTH entries, kept sorted by key in a row of
// cells. Lower keys leave first, equal keys leave in arrival order.
// Request channel req_i: op (insert or remove), priority_req, payload.
// Response channel rsp_o: status, out_priority, out_payload, occupancy.
// Every request transfer gives exactly one response transfer.
// The response is registered and valid in the cycle after the transfer.
// Throughput: one request per cycle unless the response stalls; insert
// shifts cells keyed above the broadcast key by one place, remove all.
// Insert on a full queue drops the item with status full; remove on an
// empty queue returns status empty; both leave the queue unchanged.
// A stalled response holds in the output register; a new request is taken
// in the same cycle that the held response is taken.
// Reset empties the queue and clears the response valid; no clearing pass.
module stable_sorted_priority_queue
  import sspq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  sspq_req_if.sink   req_i,
  sspq_rsp_if.source rsp_o
);

  logic [CNT_W-1:0]  count_q, count_d;
  logic              rsp_valid_q;
  sspq_status_e      status_q, status_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [TAG_W-1:0]  tag_q, tag_d;

  logic        xfer, full, empty, is_rem;
  sspq_ctrl_t  ctrl;
  sspq_entry_t new_entry;
  sspq_entry_t cell_entry [DEPTH];
  logic        cell_stay  [DEPTH];
  logic        cell_occ   [DEPTH];

  // request handshake
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign xfer        = req_i.valid && req_i.ready;
  assign full        = (count_q == CNT_W'(DEPTH));
  assign empty       = (count_q == '0);
  assign is_rem      = (req_i.op == OP_REMOVE);

  assign new_entry.key = req_i.priority_req;
  assign new_entry.tag = PAYLOAD_BITS'(req_i.payload);

  assign ctrl.ins = xfer && !is_rem && !full;
  assign ctrl.rem = xfer && is_rem && !empty;

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sspq_entry_t left_e, right_e;
    logic        left_s;

    assign cell_occ[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign left_s = 1'b1;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_s = cell_stay[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = new_entry;
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    sspq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_i       (new_entry),
      .left_i      (left_e),
      .left_stay_i (left_s),
      .right_i     (right_e),
      .occ_i       (cell_occ[i]),
      .stay_o      (cell_stay[i]),
      .entry_o     (cell_entry[i])
    );
  end

  // count update and response contents
  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    prio_d   = prio_q;
    tag_d    = tag_q;
    if (xfer) begin
      prio_d = '0;
      tag_d  = '0;
      if (is_rem) begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d = ST_REMOVED;
          prio_d   = cell_entry[0].key;
          tag_d    = TAG_W'(cell_entry[0].tag);
          count_d  = count_q - CNT_W'(1);
        end
      end else begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          count_d  = count_q + CNT_W'(1);
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (xfer) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // response payload register
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    prio_q   <= prio_d;
    tag_q    <= tag_d;
  end

  logic [OCC_W-1:0] occ_q;
  always_ff @(posedge clk_i) begin
    if (xfer) begin
      occ_q <= OCC_W'(count_d);
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.out_priority = prio_q;
  assign rsp_o.out_payload  = tag_q;
  assign rsp_o.occupancy    = occ_q;

endmodule

// ===== design/sspq_cell.sv =====
// one slot of the sorted row: holds an entry and shifts left or right
module sspq_cell
  import sspq_pkg::*;
(
  input  logic        clk_i,
  input  sspq_ctrl_t  ctrl_i,
  input  sspq_entry_t new_i,
  input  sspq_entry_t left_i,
  input  logic        left_stay_i,
  input  sspq_entry_t right_i,
  input  logic        occ_i,
  output logic        stay_o,
  output sspq_entry_t entry_o
);

  sspq_entry_t entry_q, entry_d;

  // entry keeps its place on insert when its key is lower or equal
  assign stay_o = occ_i && (entry_q.key <= new_i.key);

  // select from self, new entry or a neighbor
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (stay_o) begin
        entry_d = entry_q;
      end else if (left_stay_i) begin
        entry_d = new_i;
      end else begin
        entry_d = left_i;
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== tb/sv/stable_sorted_priority_queue_tb.sv =====
// self-checking testbench for the stable sorted priority queue
`timescale 1ns / 100ps

module stable_sorted_priority_queue_tb;
  import sspq_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int PHASE_ITEMS    = 356;

  // one response as seen on the response channel
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [PRIO_W-1:0] key_out;
    logic [TAG_W-1:0]  tag_out;
    logic [OCC_W-1:0]  occ;
  } queue_rsp_t;

  // one request, with an optional hand-written response
  typedef struct {
    sspq_op_e          op;
    logic [PRIO_W-1:0] key;
    logic [TAG_W-1:0]  tag;
    bit                typed;
    queue_rsp_t        want;
  } queue_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sspq_req_if req_if ();
  sspq_rsp_if rsp_if ();

  stable_sorted_priority_queue i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // predictor state: entries in service order
  logic [PRIO_W-1:0]       model_key [DEPTH];
  logic [PAYLOAD_BITS-1:0] model_tag [DEPTH];
  int                      model_len = 0;

  // requests in flight on the channel, and responses still owed
  queue_req_t req_note_q [$];
  queue_rsp_t expected_rsp_q [$];

  int error_count        = 0;
  int quiet_cycles       = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int n_inserted         = 0;
  int n_removed          = 0;
  int n_empty            = 0;
  int n_full             = 0;
  int n_checked          = 0;

  // apply one request to the sorted list and return its response
  function automatic queue_rsp_t queue_model_apply(logic [OP_W-1:0] op,
                                                   logic [PRIO_W-1:0] key,
                                                   logic [TAG_W-1:0] tag);
    queue_rsp_t res;
    int         pos;
    int         i;
    res.key_out = '0;
    res.tag_out = '0;
    if (op == OP_INSERT) begin
      if (model_len >= DEPTH) begin
        res.status = ST_FULL;
        n_full++;
      end else begin
        // goes behind every entry with a lower or equal key
        pos = 0;
        while (pos < model_len && model_key[pos] <= key) pos++;
        for (i = model_len; i > pos; i--) begin
          model_key[i] = model_key[i-1];
          model_tag[i] = model_tag[i-1];
        end
        model_key[pos] = key;
        model_tag[pos] = tag[PAYLOAD_BITS-1:0];
        model_len++;
        res.status = ST_INSERTED;
        n_inserted++;
      end
    end else if (model_len == 0) begin
      res.status = ST_EMPTY;
      n_empty++;
    end else begin
      // pop the head and close the gap
      res.status  = ST_REMOVED;
      res.key_out = model_key[0];
      res.tag_out = TAG_W'(model_tag[0]);
      model_len--;
      for (i = 0; i < model_len; i++) begin
        model_key[i] = model_key[i+1];
        model_tag[i] = model_tag[i+1];
      end
      n_removed++;
    end
    res.occ = OCC_W'(model_len);
    return res;
  endfunction

  // receiver: random backpressure
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // monitor: check responses, predict on each request transfer
  always @(posedge clk_i) begin : monitor
    queue_rsp_t want;
    queue_rsp_t pred;
    queue_req_t note;
    bit         moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (rsp_if.valid && rsp_if.ready) begin
        moved = 1'b1;
        if (expected_rsp_q.size() == 0) begin
          $error("response transfer with no request outstanding");
          error_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          n_checked++;
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            error_count++;
          end
          if (rsp_if.out_priority !== want.key_out) begin
            $error("out_priority: expected %0d, got %0d", want.key_out,
                   rsp_if.out_priority);
            error_count++;
          end
          if (rsp_if.out_payload !== want.tag_out) begin
            $error("out_payload: expected %h, got %h", want.tag_out,
                   rsp_if.out_payload);
            error_count++;
          end
          if (rsp_if.occupancy !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, rsp_if.occupancy);
            error_count++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        moved = 1'b1;
        note  = req_note_q.pop_front();
        pred  = queue_model_apply(req_if.op, req_if.priority_req, req_if.payload);
        expected_rsp_q.push_back(note.typed ? note.want : pred);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog: too long with no transfer on either channel
  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
    $display("stable_sorted_priority_queue: mismatch");
    $finish;
  end

  // drive one request and hold it until the transfer
  task automatic send_request(input queue_req_t item);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= item.op;
    req_if.priority_req <= item.key;
    req_if.payload      <= item.tag;
    req_note_q.push_back(item);
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // hold off until every owed response has come back
  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0 || req_note_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic queue_req_t make_row(sspq_op_e op, logic [PRIO_W-1:0] key,
                                          logic [TAG_W-1:0] tag, bit typed,
                                          sspq_status_e status,
                                          logic [PRIO_W-1:0] key_out,
                                          logic [TAG_W-1:0] tag_out,
                                          logic [OCC_W-1:0] occ);
    queue_req_t row;
    row.op           = op;
    row.key          = key;
    row.tag          = tag;
    row.typed        = typed;
    row.want.status  = status;
    row.want.key_out = key_out;
    row.want.tag_out = tag_out;
    row.want.occ     = occ;
    return row;
  endfunction

  // random requests; insert bias and key spread change every 40 requests
  task automatic run_random_phase(input int n_items);
    queue_req_t item;
    int         insert_pct;
    int         sel;
    int         n;
    bit         narrow_keys;
    insert_pct  = 50;
    narrow_keys = 1'b0;
    for (n = 0; n < n_items; n++) begin
      if (n % 40 == 0) begin
        sel         = $urandom_range(0, 2);
        insert_pct  = (sel == 0) ? 20 : (sel == 1) ? 50 : 80;
        narrow_keys = ($urandom_range(0, 2) == 0);
      end
      item.op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      sel     = $urandom_range(0, 9);
      if (narrow_keys) item.key = PRIO_W'($urandom_range(0, 3));
      else if (sel == 0) item.key = '0;
      else if (sel == 1) item.key = '1;
      else item.key = PRIO_W'($urandom_range(0, 255));
      item.tag   = $urandom();
      item.typed = 1'b0;
      send_request(item);
    end
  endtask

  // directed rows: extremes, empty and full cases, ties on equal keys
  localparam logic [PRIO_W-1:0] FILL_KEYS [16] = '{
    8'h80, 8'h80, 8'h01, 8'h80, 8'hFE, 8'h01, 8'h00, 8'hFF,
    8'h80, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h00, 8'hFF, 8'h7F
  };

  queue_req_t directed_q [$];

  initial begin : stimulus
    int idle_by_phase  [4];
    int stall_by_phase [4];
    int p;
    int k;
    idle_by_phase  = '{0, 50, 0, 35};
    stall_by_phase = '{0, 0, 50, 35};

    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.op           = OP_INSERT;
    req_if.priority_req = '0;
    req_if.payload      = '0;
    rsp_if.ready        = 1'b0;

    directed_q.push_back(make_row(OP_REMOVE, 8'h00, 32'h0000_0000, 1'b1,
                                  ST_EMPTY, 8'h00, 32'h0000_0000, 5'd0));
    directed_q.push_back(make_row(OP_INSERT, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                                  ST_INSERTED, 8'h00, 32'h0000_0000, 5'd1));
    directed_q.push_back(make_row(OP_INSERT, 8'h00, 32'h0000_0000, 1'b1,
                                  ST_INSERTED, 8'h00, 32'h0000_0000, 5'd2));
    directed_q.push_back(make_row(OP_REMOVE, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                                  ST_REMOVED, 8'h00, 32'h0000_0000, 5'd1));
    directed_q.push_back(make_row(OP_REMOVE, 8'h00, 32'h0000_0000, 1'b1,
                                  ST_REMOVED, 8'hFF, 32'hFFFF_FFFF, 5'd0));
    directed_q.push_back(make_row(OP_REMOVE, 8'h00, 32'h0000_0000, 1'b1,
                                  ST_EMPTY, 8'h00, 32'h0000_0000, 5'd0));
    // fill to the brim; repeated keys must leave in arrival order
    for (k = 0; k < 16; k++) begin
      directed_q.push_back(make_row(OP_INSERT, FILL_KEYS[k],
                                    (k == 7) ? 32'hFFFF_FFFF : 32'h5A5A_0000 | k,
                                    1'b0, ST_INSERTED, '0, '0, '0));
    end
    directed_q.push_back(make_row(OP_INSERT, 8'h00, 32'h1234_5678, 1'b1,
                                  ST_FULL, 8'h00, 32'h0000_0000, 5'd16));
    directed_q.push_back(make_row(OP_REMOVE, 8'h00, 32'h0000_0000, 1'b0,
                                  ST_INSERTED, '0, '0, '0));
    directed_q.push_back(make_row(OP_INSERT, 8'h80, 32'hC3C3_C3C3, 1'b0,
                                  ST_INSERTED, '0, '0, '0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[r]) send_request(directed_q[r]);
    wait_for_drain();

    // random part, one idling pattern per phase, drained in between
    for (p = 0; p < 4; p++) begin
      sender_idle_pct    = idle_by_phase[p];
      receiver_stall_pct = stall_by_phase[p];
      run_random_phase(PHASE_ITEMS);
      wait_for_drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d requests: %0d inserts, %0d removes, %0d empty removes, %0d full inserts",
             n_inserted + n_removed + n_empty + n_full, n_inserted, n_removed,
             n_empty, n_full);
    $display("%0d responses checked over four idling patterns, %0d errors",
             n_checked, error_count);
    if (error_count == 0) begin
      $display("stable_sorted_priority_queue: match");
    end else begin
      $display("stable_sorted_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
